// ===== hdl/seg_pkg.sv =====
`timescale 1ns / 1ps

package seg_pkg;

    // default coordinate width, signed fixed point (fraction scaling cancels in the quotient)
    localparam int SEG_COORD_BITS = 16;

    // latency in cycles, when the output does not stall, for a given coordinate width
    function automatic int seg_latency(input int coord_bits);
        return coord_bits + 8;
    endfunction

endpackage

// ===== hdl/segment_intersection.sv =====
`timescale 1ns / 1ps
// throughput: one transaction per cycle while the output does not stall; five arithmetic stages,
//   a sign stage, then one restoring divide step per stage for each coordinate, then the box test
// a stall on the output holds the whole pipeline and loses nothing
// reset: asynchronous active low, clears all valid bits; payload is not reset
module segment_intersection #(
    parameter int COORD_BITS = seg_pkg::SEG_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] first_start_x,
    input  logic signed [COORD_BITS-1:0] first_start_y,
    input  logic signed [COORD_BITS-1:0] first_end_x,
    input  logic signed [COORD_BITS-1:0] first_end_y,
    input  logic signed [COORD_BITS-1:0] second_start_x,
    input  logic signed [COORD_BITS-1:0] second_start_y,
    input  logic signed [COORD_BITS-1:0] second_end_x,
    input  logic signed [COORD_BITS-1:0] second_end_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic signed [COORD_BITS-1:0] cross_x,
    output logic signed [COORD_BITS-1:0] cross_y
);
    import seg_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int DW  = 2 * C + 3;          // determinant width
    localparam int NW  = 3 * C + 3;          // numerator width
    localparam int Q   = C + 1;              // quotient magnitude bits
    localparam int LAT = seg_latency(C);
    localparam int NV  = LAT - 1;            // valid bits ahead of the output register

    typedef struct packed {
        logic                   zero;
        logic                   sign_x;
        logic                   sign_y;
        logic                   big_x;
        logic                   big_y;
        logic [DW-1:0]          dmag;
        logic [NW-1:0]          rem_x;
        logic [NW-1:0]          rem_y;
        logic [Q-1:0]           quo_x;
        logic [Q-1:0]           quo_y;
        logic signed [C-1:0]    lox;
        logic signed [C-1:0]    hix;
        logic signed [C-1:0]    loy;
        logic signed [C-1:0]    hiy;
    } div_t;

    logic en;
    logic [NV-1:0] vld_reg;
    logic out_valid_reg;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // valid bits move with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NV-2:0], in_valid};
            out_valid_reg <= vld_reg[NV-1];
        end
    end

    // stage 1: differences and per-segment extents
    logic signed [C-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg, ex_reg, ey_reg;
    logic signed [C:0]   dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic signed [C-1:0] minabx_reg, maxabx_reg, mincex_reg, maxcex_reg;
    logic signed [C-1:0] minaby_reg, maxaby_reg, mincey_reg, maxcey_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= first_start_x;
            ay_reg <= first_start_y;
            bx_reg <= first_end_x;
            by_reg <= first_end_y;
            cx_reg <= second_start_x;
            cy_reg <= second_start_y;
            ex_reg <= second_end_x;
            ey_reg <= second_end_y;
            dx1_reg <= (C+1)'(first_start_x) - (C+1)'(first_end_x);
            dy1_reg <= (C+1)'(first_start_y) - (C+1)'(first_end_y);
            dx2_reg <= (C+1)'(second_start_x) - (C+1)'(second_end_x);
            dy2_reg <= (C+1)'(second_start_y) - (C+1)'(second_end_y);
            minabx_reg <= (first_start_x < first_end_x) ? first_start_x : first_end_x;
            maxabx_reg <= (first_start_x < first_end_x) ? first_end_x : first_start_x;
            mincex_reg <= (second_start_x < second_end_x) ? second_start_x : second_end_x;
            maxcex_reg <= (second_start_x < second_end_x) ? second_end_x : second_start_x;
            minaby_reg <= (first_start_y < first_end_y) ? first_start_y : first_end_y;
            maxaby_reg <= (first_start_y < first_end_y) ? first_end_y : first_start_y;
            mincey_reg <= (second_start_y < second_end_y) ? second_start_y : second_end_y;
            maxcey_reg <= (second_start_y < second_end_y) ? second_end_y : second_start_y;
        end
    end

    // stage 2: first products and the common box
    logic signed [2*C+1:0] pd1_reg, pd2_reg;
    logic signed [2*C-1:0] pab_reg, pba_reg, pce_reg, pec_reg;
    logic signed [C:0]     dx1b_reg, dy1b_reg, dx2b_reg, dy2b_reg;
    logic signed [C-1:0]   lox2_reg, hix2_reg, loy2_reg, hiy2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd1_reg  <= dx1_reg * dy2_reg;
            pd2_reg  <= dy1_reg * dx2_reg;
            pab_reg  <= ax_reg * by_reg;
            pba_reg  <= ay_reg * bx_reg;
            pce_reg  <= cx_reg * ey_reg;
            pec_reg  <= cy_reg * ex_reg;
            dx1b_reg <= dx1_reg;
            dy1b_reg <= dy1_reg;
            dx2b_reg <= dx2_reg;
            dy2b_reg <= dy2_reg;
            lox2_reg <= (minabx_reg > mincex_reg) ? minabx_reg : mincex_reg;
            hix2_reg <= (maxabx_reg < maxcex_reg) ? maxabx_reg : maxcex_reg;
            loy2_reg <= (minaby_reg > mincey_reg) ? minaby_reg : mincey_reg;
            hiy2_reg <= (maxaby_reg < maxcey_reg) ? maxaby_reg : maxcey_reg;
        end
    end

    // stage 3: determinant and the two cross terms
    logic signed [DW-1:0]  det3_reg;
    logic signed [2*C:0]   pre_reg, post_reg;
    logic signed [C:0]     dx1c_reg, dy1c_reg, dx2c_reg, dy2c_reg;
    logic signed [C-1:0]   lox3_reg, hix3_reg, loy3_reg, hiy3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det3_reg <= DW'(pd1_reg) - DW'(pd2_reg);
            pre_reg  <= (2*C+1)'(pab_reg) - (2*C+1)'(pba_reg);
            post_reg <= (2*C+1)'(pce_reg) - (2*C+1)'(pec_reg);
            dx1c_reg <= dx1b_reg;
            dy1c_reg <= dy1b_reg;
            dx2c_reg <= dx2b_reg;
            dy2c_reg <= dy2b_reg;
            lox3_reg <= lox2_reg;
            hix3_reg <= hix2_reg;
            loy3_reg <= loy2_reg;
            hiy3_reg <= hiy2_reg;
        end
    end

    // stage 4: numerator products
    logic signed [3*C+1:0] mx1_reg, mx2_reg, my1_reg, my2_reg;
    logic signed [DW-1:0]  det4_reg;
    logic signed [C-1:0]   lox4_reg, hix4_reg, loy4_reg, hiy4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx1_reg  <= pre_reg * dx2c_reg;
            mx2_reg  <= dx1c_reg * post_reg;
            my1_reg  <= pre_reg * dy2c_reg;
            my2_reg  <= dy1c_reg * post_reg;
            det4_reg <= det3_reg;
            lox4_reg <= lox3_reg;
            hix4_reg <= hix3_reg;
            loy4_reg <= loy3_reg;
            hiy4_reg <= hiy3_reg;
        end
    end

    // stage 5: numerators
    logic signed [NW-1:0] numx_reg, numy_reg;
    logic signed [DW-1:0] det5_reg;
    logic signed [C-1:0]  lox5_reg, hix5_reg, loy5_reg, hiy5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg <= NW'(mx1_reg) - NW'(mx2_reg);
            numy_reg <= NW'(my1_reg) - NW'(my2_reg);
            det5_reg <= det4_reg;
            lox5_reg <= lox4_reg;
            hix5_reg <= hix4_reg;
            loy5_reg <= loy4_reg;
            hiy5_reg <= hiy4_reg;
        end
    end

    // stage 6: magnitudes, signs and overflow check ahead of the divide
    div_t div_reg [0:Q];
    div_t div0_next;
    logic [NW-1:0] magx, magy;
    logic [DW-1:0] magd;

    always_comb
    begin
        magx = numx_reg[NW-1] ? (NW'(0) - NW'(numx_reg)) : NW'(numx_reg);
        magy = numy_reg[NW-1] ? (NW'(0) - NW'(numy_reg)) : NW'(numy_reg);
        magd = det5_reg[DW-1] ? (DW'(0) - DW'(det5_reg)) : DW'(det5_reg);
        div0_next.zero   = (det5_reg == '0);
        div0_next.sign_x = numx_reg[NW-1] ^ det5_reg[DW-1];
        div0_next.sign_y = numy_reg[NW-1] ^ det5_reg[DW-1];
        // quotient of 2^Q or more lies outside every box
        div0_next.big_x  = {1'b0, magx} >= {magd, {Q{1'b0}}};
        div0_next.big_y  = {1'b0, magy} >= {magd, {Q{1'b0}}};
        div0_next.dmag   = magd;
        div0_next.rem_x  = magx;
        div0_next.rem_y  = magy;
        div0_next.quo_x  = '0;
        div0_next.quo_y  = '0;
        div0_next.lox    = lox5_reg;
        div0_next.hix    = hix5_reg;
        div0_next.loy    = loy5_reg;
        div0_next.hiy    = hiy5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0] <= div0_next;
        end
    end

    // restoring divide, one quotient bit per stage, most significant first
    genvar j;
    generate
        for (j = 0; j < Q; j++)
        begin : g_div
            localparam int K = Q - 1 - j;
            div_t          step_next;
            logic [NW-1:0] dsh;

            always_comb
            begin
                dsh       = NW'(div_reg[j].dmag) << K;
                step_next = div_reg[j];
                if (div_reg[j].rem_x >= dsh)
                begin
                    step_next.rem_x    = div_reg[j].rem_x - dsh;
                    step_next.quo_x[K] = 1'b1;
                end
                if (div_reg[j].rem_y >= dsh)
                begin
                    step_next.rem_y    = div_reg[j].rem_y - dsh;
                    step_next.quo_y[K] = 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    div_reg[j+1] <= step_next;
                end
            end
        end
    endgenerate

    // final stage: signed quotient and box test
    logic signed [C+1:0]  qx, qy;
    logic                 hit_next;
    logic                 hit_reg;
    logic signed [C-1:0]  cross_x_reg, cross_y_reg;

    always_comb
    begin
        qx = div_reg[Q].sign_x ? ((C+2)'(0) - (C+2)'({1'b0, div_reg[Q].quo_x}))
                               : (C+2)'({1'b0, div_reg[Q].quo_x});
        qy = div_reg[Q].sign_y ? ((C+2)'(0) - (C+2)'({1'b0, div_reg[Q].quo_y}))
                               : (C+2)'({1'b0, div_reg[Q].quo_y});
        hit_next = !div_reg[Q].zero && !div_reg[Q].big_x && !div_reg[Q].big_y
                && (qx >= (C+2)'(div_reg[Q].lox)) && (qx <= (C+2)'(div_reg[Q].hix))
                && (qy >= (C+2)'(div_reg[Q].loy)) && (qy <= (C+2)'(div_reg[Q].hiy));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg     <= hit_next;
            cross_x_reg <= hit_next ? qx[C-1:0] : '0;
            cross_y_reg <= hit_next ? qy[C-1:0] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;

endmodule

// ===== bench/segment_intersection_checker.sv =====
`timescale 1ns / 1ps

module segment_intersection_checker #(
    parameter int COORD_BITS = seg_pkg::SEG_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] first_start_x,
    input  logic signed [COORD_BITS-1:0] first_start_y,
    input  logic signed [COORD_BITS-1:0] first_end_x,
    input  logic signed [COORD_BITS-1:0] first_end_y,
    input  logic signed [COORD_BITS-1:0] second_start_x,
    input  logic signed [COORD_BITS-1:0] second_start_y,
    input  logic signed [COORD_BITS-1:0] second_end_x,
    input  logic signed [COORD_BITS-1:0] second_end_y,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         hit,
    input  logic signed [COORD_BITS-1:0] cross_x,
    input  logic signed [COORD_BITS-1:0] cross_y,
    output int                           fail_count,
    output int                           pending_count
);

    typedef struct packed {
        logic                  hit;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } crossing_t;

    crossing_t crossing_q[$];

    localparam longint CLAMP_MAG = 64'sd1 << 40;

    // exact quotient truncated toward zero, magnitude clamped
    function automatic longint clamp_div(input logic signed [127:0] num,
                                         input longint den);
        logic signed [127:0] q;
        q = num / 128'(signed'(den));
        if (q > 128'(CLAMP_MAG)) return CLAMP_MAG;
        if (q < -128'(CLAMP_MAG)) return -CLAMP_MAG;
        return longint'(q);
    endfunction

    function automatic bit in_box(input longint v, input longint p, input longint q);
        return (p < q) ? (v >= p && v <= q) : (v >= q && v <= p);
    endfunction

    function automatic crossing_t predict_crossing(
        input longint ax, input longint ay, input longint bx, input longint by,
        input longint cx, input longint cy, input longint ex, input longint ey);
        longint dx1, dy1, dx2, dy2, det, pre, post, qx, qy;
        logic signed [127:0] nx, ny;
        crossing_t r;
        r = '0;
        dx1 = ax - bx;
        dy1 = ay - by;
        dx2 = cx - ex;
        dy2 = cy - ey;
        det = dx1 * dy2 - dy1 * dx2;
        if (det == 0) return r;
        pre = ax * by - ay * bx;
        post = cx * ey - cy * ex;
        nx = 128'(signed'(pre)) * 128'(signed'(dx2)) - 128'(signed'(dx1)) * 128'(signed'(post));
        ny = 128'(signed'(pre)) * 128'(signed'(dy2)) - 128'(signed'(dy1)) * 128'(signed'(post));
        qx = clamp_div(nx, det);
        qy = clamp_div(ny, det);
        if (!in_box(qx, ax, bx) || !in_box(qx, cx, ex)) return r;
        if (!in_box(qy, ay, by) || !in_box(qy, cy, ey)) return r;
        r.hit = 1'b1;
        r.x = qx[COORD_BITS-1:0];
        r.y = qy[COORD_BITS-1:0];
        return r;
    endfunction

    assign pending_count = crossing_q.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        crossing_t want, got;
        if (rst_n && in_valid && !in_stall)
            crossing_q.push_back(predict_crossing(first_start_x, first_start_y,
                first_end_x, first_end_y, second_start_x, second_start_y,
                second_end_x, second_end_y));
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{hit, cross_x, cross_y};
            if (crossing_q.size() == 0)
            begin
                $display("%0t: unexpected transaction hit=%0b x=%0d y=%0d",
                         $time, hit, cross_x, cross_y);
                fail_count++;
            end
            else
            begin
                want = crossing_q.pop_front();
                if (want.hit !== got.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
                    fail_count++;
                end
                if (want.x !== got.x)
                begin
                    $display("%0t: cross_x expected %0d actual %0d", $time,
                             $signed(want.x), $signed(got.x));
                    fail_count++;
                end
                if (want.y !== got.y)
                begin
                    $display("%0t: cross_y expected %0d actual %0d", $time,
                             $signed(want.y), $signed(got.y));
                    fail_count++;
                end
            end
        end
    end

endmodule

// ===== bench/segment_intersection_tb.sv =====
`timescale 1ns / 1ps

module segment_intersection_tb;

    localparam int CB = seg_pkg::SEG_COORD_BITS;
    localparam int LATENCY = seg_pkg::seg_latency(CB);
    localparam int N_RANDOM = 1300;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [CB-1:0] first_start_x, first_start_y, first_end_x, first_end_y;
    logic signed [CB-1:0] second_start_x, second_start_y, second_end_x, second_end_y;
    logic out_valid;
    logic out_stall;
    logic hit;
    logic signed [CB-1:0] cross_x, cross_y;
    int fail_count;
    int pending_count;
    bit long_holdoff;

    segment_intersection #(.COORD_BITS(CB)) i_dut (.*);

    segment_intersection_checker #(.COORD_BITS(CB)) i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int mode;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_holdoff)
            begin
                out_stall <= 1'b1;
                repeat (LATENCY * 4) @(posedge clk);
                long_holdoff = 1'b0;
            end
            mode = $urandom_range(0, 9);
            if (mode < 4)
                out_stall <= 1'b0;
            else if (mode < 7)
                out_stall <= $urandom_range(0, 1);
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    localparam int MAXC = 2 ** (CB - 1) - 1;
    localparam int MINC = -(2 ** (CB - 1));

    // only the low CB bits of a coordinate reach the block
    function automatic int rand_coord(input int kind);
        case (kind)
            0: return int'($urandom());
            1: return int'($urandom_range(0, 255)) - 128;
            2: return $urandom_range(0, 1) ? MAXC : MINC;
            default: return int'($urandom_range(0, 4095)) - 2048;
        endcase
    endfunction

    task automatic send_pair(input int ax, ay, bx, by, cx, cy, ex, ey);
        in_valid <= 1'b1;
        first_start_x <= CB'(ax);
        first_start_y <= CB'(ay);
        first_end_x <= CB'(bx);
        first_end_y <= CB'(by);
        second_start_x <= CB'(cx);
        second_start_y <= CB'(cy);
        second_end_x <= CB'(ex);
        second_end_y <= CB'(ey);
        do @(posedge clk); while (in_stall);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_random(input int kind);
        int v[8];
        int c;
        // crossing segments through a shared center hit often
        if (kind == 4)
        begin
            c = rand_coord(3);
            v[0] = c - int'($urandom_range(1, 500)); v[2] = c + int'($urandom_range(1, 500));
            v[1] = c - int'($urandom_range(0, 500)); v[3] = c + int'($urandom_range(0, 500));
            v[4] = c + int'($urandom_range(0, 500)); v[6] = c - int'($urandom_range(0, 500));
            v[5] = c - int'($urandom_range(1, 500)); v[7] = c + int'($urandom_range(1, 500));
        end
        else
            foreach (v[i]) v[i] = rand_coord($urandom_range(0, 1) ? kind
                                                                 : int'($urandom_range(0, 3)));
        send_pair(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endtask

    initial
    begin
        int burst;
        bit holdoff_done;
        bit drain_done;
        rst_n = 1'b0;
        in_valid = 1'b0;
        long_holdoff = 1'b0;
        holdoff_done = 1'b0;
        drain_done = 1'b0;
        {first_start_x, first_start_y, first_end_x, first_end_y} = '0;
        {second_start_x, second_start_y, second_end_x, second_end_y} = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // simple cross
        send_pair(-16, 0, 16, 0, 0, -16, 0, 16);
        // parallel and degenerate
        send_pair(0, 0, 16, 16, 0, 16, 16, 32);
        send_pair(5, 5, 5, 5, 5, 5, 5, 5);
        send_pair(0, 0, 0, 0, 1, 2, 3, 4);
        // lines cross outside the boxes
        send_pair(0, 0, 16, 0, 100, -16, 100, 16);
        // touching at an endpoint, bounds inclusive
        send_pair(0, 0, 32, 0, 32, 0, 32, 32);
        // negative quotient truncation
        send_pair(-3, -7, 11, 5, -9, 4, 6, -13);
        // full-scale extremes
        send_pair(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
        send_pair(MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC);
        send_pair(MINC, 0, MAXC, 0, 0, MINC, 0, MAXC);
        send_pair(MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC);
        // nearly parallel gives a huge quotient
        send_pair(MINC, MINC, MAXC, MAXC, MINC, MINC + 1, MAXC, MAXC);
        send_pair(0, 0, MAXC, 1, 0, 1, MAXC, 2);
        send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
        send_pair(-1, 0, 0, -1, 0, 0, -1, -1);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n >= 300 && !holdoff_done)
            begin
                holdoff_done = 1'b1;
                long_holdoff = 1'b1;
            end
            if (n >= 700 && !drain_done)
            begin
                drain_done = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_count != 0) @(posedge clk);
            end
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
                send_random($urandom_range(0, 4) == 4 ? 4 : int'($urandom_range(0, 4)));
            n--;
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 8));
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending_count != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
